### src/imu_cal_pkg.sv
// shared constants, types and register indexes for the imu offset calibration block
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package imu_cal_pkg;

  // batch and physical constants
  localparam int BATCH_SIZE    = 5;
  localparam int GRAVITY_VALUE = 9800;
  localparam int AXES          = 6;
  localparam int AX_Y          = 1;

  // field widths
  localparam int SMP_W  = 16;
  localparam int LIM_W  = 18;
  localparam int OUT_W  = 18;
  localparam int FAIL_W = 3;
  localparam int DEV_W  = SMP_W;
  localparam int DSUM_W = DEV_W + 2;
  localparam int IDX_W  = $clog2(BATCH_SIZE);
  localparam int SUM_W  = SMP_W + $clog2(BATCH_SIZE);

  // divide by the batch size as a multiply by a rounded-up reciprocal
  localparam int DIV_SHIFT = 21;
  localparam int MUL_W     = DIV_SHIFT;
  localparam int DIV_MUL   = (2 ** DIV_SHIFT + BATCH_SIZE - 1) / BATCH_SIZE;

  // stream widths
  localparam int IN_TDATA_W  = AXES * SMP_W;
  localparam int OUT_TDATA_W = ((FAIL_W + AXES * OUT_W + 7) / 8) * 8;

  // configuration port
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = LIM_W;

  localparam logic [CFG_IDX_W-1:0] REG_ACCEL_LIMIT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GYRO_LIMIT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_BASE = 3'd2;

  localparam int ACCEL_LIMIT_RST = 150;
  localparam int GYRO_LIMIT_RST  = 20;

  // control from the sequencer to every lane
  typedef struct packed {
    logic             wr;
    logic [IDX_W-1:0] slot;
    logic             avg_en;
    logic [IDX_W-1:0] rd_idx;
  } lane_ctl_t;

  // control from the sequencer to the merging stage
  typedef struct packed {
    logic             clr;
    logic             vld;
    logic [IDX_W-1:0] idx;
  } walk_t;

endpackage

### src/imu_cal_lane.sv
// one axis lane: sample store, running sum, average and absolute deviation
// depends on imu_cal_pkg
`timescale 1ns / 1ps

module imu_cal_lane import imu_cal_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  lane_ctl_t               ctl_i,
  input  logic signed [SMP_W-1:0] sample_i,
  output logic signed [SMP_W-1:0] avg_o,
  output logic        [DEV_W-1:0] dev_o
);

  logic signed [SUM_W-1:0]       sum_q, sum_d;
  logic signed [SMP_W-1:0]       store_q [BATCH_SIZE];
  logic signed [SMP_W-1:0]       avg_q, avg_d;
  logic        [DEV_W-1:0]       dev_q, dev_d;
  logic                          sum_neg;
  logic        [SUM_W-1:0]       sum_mag;
  logic        [SUM_W+MUL_W-1:0] prod;
  logic        [SMP_W:0]         quo;
  logic signed [SMP_W:0]         diff;

  always_comb begin
    sum_d = sum_q;
    if (ctl_i.wr) begin
      sum_d = sum_q + SUM_W'(sample_i);
    end
    if (ctl_i.avg_en) begin
      sum_d = '0;
    end
  end

  // truncating divide: magnitude times reciprocal, sign put back
  always_comb begin
    sum_neg = sum_q[SUM_W-1];
    sum_mag = sum_neg ? SUM_W'(-sum_q) : SUM_W'(sum_q);
    prod    = sum_mag * MUL_W'(DIV_MUL);
    quo     = prod[DIV_SHIFT +: SMP_W+1];
    avg_d   = sum_neg ? SMP_W'(-quo) : SMP_W'(quo);
  end

  always_comb begin
    diff  = (SMP_W+1)'(avg_q) - (SMP_W+1)'(store_q[ctl_i.rd_idx]);
    dev_d = diff[SMP_W] ? DEV_W'(-diff) : DEV_W'(diff);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else begin
      sum_q <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr) begin
      store_q[ctl_i.slot] <= sample_i;
    end
    if (ctl_i.avg_en) begin
      avg_q <= avg_d;
    end
    dev_q <= dev_d;
  end

  assign avg_o = avg_q;
  assign dev_o = dev_q;

endmodule

### src/imu_cal_merge.sv
// merging stage: adds lane deviations per sensor, checks limits, keeps first failure
// depends on imu_cal_pkg
`timescale 1ns / 1ps

module imu_cal_merge import imu_cal_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  walk_t            walk_i,
  input  logic [DEV_W-1:0] dev_i [AXES],
  input  logic [LIM_W-1:0] accel_limit_i,
  input  logic [LIM_W-1:0] gyro_limit_i,
  output logic             ok_o,
  output logic [IDX_W-1:0] bad_o
);

  logic              ok_q;
  logic [IDX_W-1:0]  bad_q;
  logic [DSUM_W-1:0] acc_dev;
  logic [DSUM_W-1:0] gyr_dev;
  logic              over;

  always_comb begin
    acc_dev = DSUM_W'(dev_i[0]) + DSUM_W'(dev_i[1]) + DSUM_W'(dev_i[2]);
    gyr_dev = DSUM_W'(dev_i[3]) + DSUM_W'(dev_i[4]) + DSUM_W'(dev_i[5]);
    over    = (LIM_W'(acc_dev) > accel_limit_i) || (LIM_W'(gyr_dev) > gyro_limit_i);
  end

  // only the first failing sample is recorded
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ok_q  <= 1'b1;
      bad_q <= '0;
    end else if (walk_i.clr) begin
      ok_q  <= 1'b1;
      bad_q <= '0;
    end else if (walk_i.vld && ok_q && over) begin
      ok_q  <= 1'b0;
      bad_q <= walk_i.idx;
    end
  end

  assign ok_o  = ok_q;
  assign bad_o = bad_q;

endmodule

### src/imu_offset_calibration.sv
// channel   dir  handshake                     payload
// s_axis    in   s_axis_tvalid/s_axis_tready   tdata: six 16 bit imu readings
// m_axis    out  m_axis_tvalid/m_axis_tready   tdata: failed index + six offsets, tuser: passed
// cfg       in   cfg_we_i (no back-pressure)   cfg_idx_i, cfg_wdata_i
//
// the last sample of a batch keeps the input closed while the block averages, the six
// lanes walk the store one stored sample at a time, the merge finishes and the result
// is loaded.
// the load waits while an earlier result is still not taken downstream.
// reset is asynchronous and active low; limits and offsets return to their defaults.
// top level of the imu offset calibration; depends on imu_cal_pkg, imu_cal_lane, imu_cal_merge
`timescale 1ns / 1ps

module imu_offset_calibration import imu_cal_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // failed_sample, new_offset_ax, ay, az, gx, gy, gz, zero pad
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // passed
  output logic                   m_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_W-1:0]       cfg_wdata_i
);

  typedef enum logic [2:0] {
    ST_COLLECT,
    ST_AVG,
    ST_WALK,
    ST_DRAIN,
    ST_FIN
  } state_e;

  state_e                   state_q;
  logic [IDX_W-1:0]         cnt_q;
  logic [IDX_W-1:0]         walk_q;
  logic                     dev_vld_q;
  logic [IDX_W-1:0]         dev_idx_q;
  logic                     m_valid_q;
  logic [OUT_TDATA_W-1:0]   m_tdata_q, m_tdata_d;
  logic                     m_tuser_q;

  logic [LIM_W-1:0]         accel_limit_q;
  logic [LIM_W-1:0]         gyro_limit_q;
  logic signed [SMP_W-1:0]  old_q [AXES];

  lane_ctl_t                lane_ctl;
  walk_t                    walk;
  logic signed [SMP_W-1:0]  avg [AXES];
  logic        [DEV_W-1:0]  dev [AXES];
  logic                     ok;
  logic [IDX_W-1:0]         bad;
  logic signed [OUT_W-1:0]  new_off [AXES];
  logic                     s_xfer;
  logic                     out_free;

  assign s_axis_tready = (state_q == ST_COLLECT);
  assign s_xfer        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;

  always_comb begin
    lane_ctl.wr     = s_xfer;
    lane_ctl.slot   = cnt_q;
    lane_ctl.avg_en = (state_q == ST_AVG);
    lane_ctl.rd_idx = walk_q;
    walk.clr        = (state_q == ST_AVG);
    walk.vld        = dev_vld_q;
    walk.idx        = dev_idx_q;
  end

  for (genvar a = 0; a < AXES; a++) begin : g_lane
    imu_cal_lane u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctl_i    (lane_ctl),
      .sample_i (s_axis_tdata[a*SMP_W +: SMP_W]),
      .avg_o    (avg[a]),
      .dev_o    (dev[a])
    );
  end

  imu_cal_merge u_merge (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .walk_i        (walk),
    .dev_i         (dev),
    .accel_limit_i (accel_limit_q),
    .gyro_limit_i  (gyro_limit_q),
    .ok_o          (ok),
    .bad_o         (bad)
  );

  // new offsets, or old ones sign-extended when the batch failed
  always_comb begin
    m_tdata_d = '0;
    m_tdata_d[FAIL_W-1:0] = ok ? '0 : FAIL_W'(bad);
    for (int a = 0; a < AXES; a++) begin
      new_off[a] = OUT_W'(old_q[a]);
      if (ok) begin
        new_off[a] = OUT_W'(old_q[a]) + OUT_W'(avg[a]);
        if (a == AX_Y) begin
          new_off[a] = new_off[a] - OUT_W'(GRAVITY_VALUE);
        end
      end
      m_tdata_d[FAIL_W + a*OUT_W +: OUT_W] = new_off[a];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accel_limit_q <= LIM_W'(ACCEL_LIMIT_RST);
      gyro_limit_q  <= LIM_W'(GYRO_LIMIT_RST);
      for (int a = 0; a < AXES; a++) begin
        old_q[a] <= '0;
      end
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_ACCEL_LIMIT) begin
        accel_limit_q <= cfg_wdata_i;
      end
      if (cfg_idx_i == REG_GYRO_LIMIT) begin
        gyro_limit_q <= cfg_wdata_i;
      end
      for (int a = 0; a < AXES; a++) begin
        if (cfg_idx_i == REG_OFFSET_BASE + CFG_IDX_W'(a)) begin
          old_q[a] <= cfg_wdata_i[SMP_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_COLLECT;
      cnt_q     <= '0;
      walk_q    <= '0;
      dev_vld_q <= 1'b0;
      dev_idx_q <= '0;
      m_valid_q <= 1'b0;
      m_tdata_q <= '0;
      m_tuser_q <= 1'b0;
    end else begin
      dev_vld_q <= (state_q == ST_WALK);
      dev_idx_q <= walk_q;
      if (state_q == ST_FIN && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_COLLECT: begin
          if (s_xfer) begin
            if (cnt_q == IDX_W'(BATCH_SIZE - 1)) begin
              cnt_q   <= '0;
              state_q <= ST_AVG;
            end else begin
              cnt_q <= cnt_q + 1'b1;
            end
          end
        end
        ST_AVG: begin
          walk_q  <= '0;
          state_q <= ST_WALK;
        end
        ST_WALK: begin
          if (walk_q == IDX_W'(BATCH_SIZE - 1)) begin
            state_q <= ST_DRAIN;
          end else begin
            walk_q <= walk_q + 1'b1;
          end
        end
        ST_DRAIN: begin
          state_q <= ST_FIN;
        end
        ST_FIN: begin
          if (out_free) begin
            m_tdata_q <= m_tdata_d;
            m_tuser_q <= ok;
            state_q   <= ST_COLLECT;
          end
        end
        default: begin
          state_q <= ST_COLLECT;
        end
      endcase
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_tdata_q;
  assign m_axis_tuser  = m_tuser_q;

endmodule

### src/imu_cal_checker.sv
// port-level checks for imu_offset_calibration, attached by a bind statement
// depends on imu_cal_pkg and the top level's port names
`timescale 1ns / 1ps

module imu_cal_checker import imu_cal_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                   m_axis_tuser,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // a passing batch reports index zero
  a_pass_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[FAIL_W-1:0] == '0)
    else $error("passed result with nonzero failed index");

  a_fail_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[FAIL_W-1:0] < FAIL_W'(BATCH_SIZE))
    else $error("failed index outside the batch");

  // loading a result returns the block to collecting
  a_resume: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> s_axis_tready)
    else $error("input not reopened after result load");

endmodule

bind imu_offset_calibration imu_cal_checker u_imu_cal_checker (.*);
